FILE: rtl/jkse_pkg.sv
// Package with shared types, codes and constants of the JSON key string value extractor.
`timescale 1ns / 1ps

package jkse_pkg;

	// Largest key that the key registers hold, in characters.
	localparam int KEY_BYTES = 16;
	localparam int KEY_POS_W = 5;
	localparam int KEY_LEN_W = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;

	// Depth of the queue between the parser and the output stage.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 2'd2;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CLOSE     = 8'h7D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_KEY_WS  = 3'd1,
		PH_KEY_CMP = 3'd2,
		PH_SCAN    = 3'd3,
		PH_COLON   = 3'd4,
		PH_VAL_WS  = 3'd5,
		PH_VALUE   = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_NONE = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	// Results caused by one document byte: the first one always, a second one optionally.
	// A second result never carries a value byte.
	typedef struct packed {
		kind_t      kind0;
		logic [7:0] byte0;
		logic       two;
		kind_t      kind1;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

FILE: rtl/jkse_ifs.sv
// Channel interfaces: document bytes in, results out and register writes.
`timescale 1ns / 1ps

interface jkse_doc_if;
	logic       valid;
	logic       ready;
	logic [7:0] doc_byte;
	logic       doc_last;

	modport source (output valid, output doc_byte, output doc_last, input ready);
	modport sink (input valid, input doc_byte, input doc_last, output ready);
endinterface

interface jkse_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] value_byte;

	modport source (output valid, output result_kind, output value_byte, input ready);
	modport sink (input valid, input result_kind, input value_byte, output ready);
endinterface

interface jkse_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [jkse_pkg::CFG_INDEX_W-1:0] index;
	logic [jkse_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/jkse_front.sv
// Parser front end: key registers, phase tracking and result classification per byte.
`timescale 1ns / 1ps

module jkse_front (
	input  logic                  clk,
	input  logic                  arst_n,
	jkse_doc_if.sink              doc,
	jkse_cfg_if.sink              cfg,
	input  jkse_pkg::queue_status_t qstat,
	output logic                  push,
	output jkse_pkg::entry_t      push_entry
);

	logic [jkse_pkg::CFG_DATA_W-1:0] key_first_q;
	logic [jkse_pkg::CFG_DATA_W-1:0] key_second_q;
	logic [jkse_pkg::KEY_LEN_W-1:0]  key_len_q;
	jkse_pkg::phase_t                phase_q;
	jkse_pkg::phase_t                phase_d;
	jkse_pkg::phase_t                phase_mid;
	logic [jkse_pkg::KEY_POS_W-1:0]  kpos_q;
	logic [jkse_pkg::KEY_POS_W-1:0]  kpos_d;
	logic                            esc_q;
	logic                            esc_d;

	logic [2*jkse_pkg::CFG_DATA_W-1:0] key_all;
	logic [7:0]                        key_char;
	logic [jkse_pkg::KEY_LEN_W-1:0]    eff_len;
	logic                              accept;
	logic                              blank;
	logic [7:0]                        b;

	logic                e_valid;
	jkse_pkg::kind_t     e_kind;
	logic [7:0]          e_byte;
	logic                t_valid;
	jkse_pkg::kind_t     t_kind;

	assign cfg.ready = 1'b1;
	assign doc.ready = !qstat.full;
	assign accept    = doc.valid && doc.ready;
	assign b         = doc.doc_byte;

	assign key_all  = {key_second_q, key_first_q};
	assign key_char = key_all[{kpos_q[3:0], 3'b000} +: 8];
	assign eff_len  = (key_len_q > jkse_pkg::KEY_LEN_W'(jkse_pkg::KEY_BYTES))
		? jkse_pkg::KEY_LEN_W'(jkse_pkg::KEY_BYTES) : key_len_q;
	assign blank = b inside {jkse_pkg::CH_SPACE, jkse_pkg::CH_NEWLINE, jkse_pkg::CH_TAB};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= '0;
			key_second_q <= '0;
			key_len_q    <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				jkse_pkg::CFG_KEY_FIRST:  key_first_q  <= cfg.data;
				jkse_pkg::CFG_KEY_SECOND: key_second_q <= cfg.data;
				jkse_pkg::CFG_KEY_LENGTH: key_len_q    <= cfg.data[jkse_pkg::KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jkse_pkg::PH_START;
			kpos_q  <= '0;
			esc_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			kpos_q  <= kpos_d;
			esc_q   <= esc_d;
		end
	end

	always_comb begin
		phase_mid = phase_q;
		kpos_d    = kpos_q;
		esc_d     = esc_q;
		e_valid   = 1'b0;
		e_kind    = jkse_pkg::KIND_BYTE;
		e_byte    = '0;
		t_valid   = 1'b0;
		t_kind    = jkse_pkg::KIND_NONE;

		case (phase_q)
			jkse_pkg::PH_START: begin
				phase_mid = jkse_pkg::PH_KEY_WS;
			end
			jkse_pkg::PH_KEY_WS: begin
				if (!blank) begin
					if (b == jkse_pkg::CH_CLOSE) begin
						e_valid   = 1'b1;
						e_kind    = jkse_pkg::KIND_NONE;
						phase_mid = jkse_pkg::PH_DONE;
					end else begin
						kpos_d    = '0;
						phase_mid = jkse_pkg::PH_KEY_CMP;
					end
				end
			end
			jkse_pkg::PH_KEY_CMP, jkse_pkg::PH_SCAN: begin
				if (phase_q == jkse_pkg::PH_KEY_CMP && kpos_q < eff_len
						&& b != jkse_pkg::CH_QUOTE && b == key_char) begin
					kpos_d = kpos_q + 1'b1;
				end else if (phase_q == jkse_pkg::PH_KEY_CMP && kpos_q >= eff_len
						&& b == jkse_pkg::CH_QUOTE) begin
					phase_mid = jkse_pkg::PH_COLON;
				end else if (b == jkse_pkg::CH_CLOSE) begin
					e_valid   = 1'b1;
					e_kind    = jkse_pkg::KIND_NONE;
					phase_mid = jkse_pkg::PH_DONE;
				end else if (b == jkse_pkg::CH_COMMA) begin
					phase_mid = jkse_pkg::PH_KEY_WS;
				end else begin
					phase_mid = jkse_pkg::PH_SCAN;
				end
			end
			jkse_pkg::PH_COLON: begin
				if (!blank) begin
					phase_mid = jkse_pkg::PH_VAL_WS;
				end
			end
			jkse_pkg::PH_VAL_WS: begin
				if (!blank) begin
					if (b == jkse_pkg::CH_QUOTE) begin
						phase_mid = jkse_pkg::PH_VALUE;
						esc_d     = 1'b0;
					end else begin
						e_valid   = 1'b1;
						e_kind    = jkse_pkg::KIND_BAD;
						phase_mid = jkse_pkg::PH_DONE;
					end
				end
			end
			jkse_pkg::PH_VALUE: begin
				if (esc_q) begin
					e_valid = 1'b1;
					e_byte  = b;
					esc_d   = 1'b0;
				end else if (b == jkse_pkg::CH_BACKSLASH) begin
					e_valid = 1'b1;
					e_byte  = b;
					esc_d   = 1'b1;
				end else if (b == jkse_pkg::CH_QUOTE) begin
					e_valid   = 1'b1;
					e_kind    = jkse_pkg::KIND_END;
					phase_mid = jkse_pkg::PH_DONE;
				end else begin
					e_valid = 1'b1;
					e_byte  = b;
				end
			end
			default: begin
				phase_mid = jkse_pkg::PH_DONE;
			end
		endcase

		// End of document: give the pending verdict and return to the start state.
		phase_d = phase_mid;
		if (doc.doc_last) begin
			if (phase_mid inside {jkse_pkg::PH_START, jkse_pkg::PH_KEY_WS,
					jkse_pkg::PH_KEY_CMP, jkse_pkg::PH_SCAN}) begin
				t_valid = 1'b1;
				t_kind  = jkse_pkg::KIND_NONE;
			end else if (phase_mid inside {jkse_pkg::PH_COLON, jkse_pkg::PH_VAL_WS,
					jkse_pkg::PH_VALUE}) begin
				t_valid = 1'b1;
				t_kind  = jkse_pkg::KIND_BAD;
			end
			phase_d = jkse_pkg::PH_START;
			kpos_d  = '0;
			esc_d   = 1'b0;
		end
	end

	always_comb begin
		if (e_valid) begin
			push_entry.kind0 = e_kind;
			push_entry.byte0 = e_byte;
			push_entry.two   = t_valid;
			push_entry.kind1 = t_kind;
		end else begin
			push_entry.kind0 = t_kind;
			push_entry.byte0 = '0;
			push_entry.two   = 1'b0;
			push_entry.kind1 = t_kind;
		end
	end

	assign push = accept && (e_valid || t_valid);

endmodule

FILE: rtl/jkse_queue.sv
// Short queue of classified result entries between the parser and the output stage.
`timescale 1ns / 1ps

module jkse_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  jkse_pkg::entry_t        push_entry,
	input  logic                    pop,
	output jkse_pkg::entry_t        head,
	output jkse_pkg::queue_status_t qstat
);

	jkse_pkg::entry_t                  mem_q [jkse_pkg::QUEUE_DEPTH];
	logic [jkse_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [jkse_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [jkse_pkg::QUEUE_CNT_W-1:0]  count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == jkse_pkg::QUEUE_CNT_W'(jkse_pkg::QUEUE_DEPTH));
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/jkse_back.sv
// Output stage: expands queue entries into single results held in an output register.
`timescale 1ns / 1ps

module jkse_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  jkse_pkg::entry_t        head,
	input  jkse_pkg::queue_status_t qstat,
	output logic                    pop,
	jkse_result_if.source           result
);

	logic            out_valid_q;
	jkse_pkg::kind_t out_kind_q;
	logic [7:0]      out_byte_q;
	logic            sel_q;
	logic            load;
	logic            take;

	assign load = !out_valid_q || result.ready;
	assign take = load && !qstat.empty;
	assign pop  = take && (!head.two || sel_q);

	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.value_byte  = out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= !qstat.empty;
			if (take) begin
				sel_q <= !pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_kind_q <= sel_q ? head.kind1 : head.kind0;
			out_byte_q <= sel_q ? 8'h00 : head.byte0;
		end
	end

endmodule

FILE: rtl/json_key_string_value_extractor_top.sv
// Top level of the JSON key string value extractor.
// The first result of a byte passes through a queue entry and then the output register.
// Throughput: one document byte per cycle while the queue has room. A byte that yields
// two results (a value byte plus the malformed verdict at document end) gives them as two
// result transactions, one after the other, from its single queue entry.
// Reset: arst_n clears the phase, the queue and the output register at once; the block
// is ready to take a byte as soon as reset is released.
`timescale 1ns / 1ps

module json_key_string_value_extractor_top (
	input  logic          clk,
	input  logic          arst_n,
	jkse_doc_if.sink      doc,
	jkse_cfg_if.sink      cfg,
	jkse_result_if.source result
);

	// The front end parses one byte per cycle. It holds the key registers and the phase
	// machine, and decides for each byte which results it causes: none, one, or one plus a
	// document end verdict. Bytes that cause results leave one entry in the queue.
	// The front end stalls only when the queue is full.
	logic                    push;
	logic                    pop;
	jkse_pkg::entry_t        push_entry;
	jkse_pkg::entry_t        head;
	jkse_pkg::queue_status_t qstat;

	jkse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.doc        (doc),
		.cfg        (cfg),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Four entries let the parser keep going while the result consumer stalls for a while.
	jkse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// The back end turns each entry into one or two result transactions through a
	// registered output, which can be refilled in the cycle that its result is taken.
	jkse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule

FILE: rtl/jkse_checker.sv
// Port-level checker of the extractor and its bind to the top level.
`timescale 1ns / 1ps

module jkse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       doc_valid,
	input logic       doc_ready,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte
);

	// A stalled result must hold its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
		else $error("result changed while stalled");

	// Only value bytes carry a character.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != jkse_pkg::KIND_BYTE |-> out_byte == 8'h00)
		else $error("non-byte result carries a character");

	// The input can only block after the queue has been filled by a transaction.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(doc_ready) |-> $past(doc_valid && doc_ready))
		else $error("input ready dropped without a transaction");

	// Register writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port refused a write");

endmodule

bind json_key_string_value_extractor_top jkse_checker u_jkse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.doc_valid (doc.valid),
	.doc_ready (doc.ready),
	.cfg_ready (cfg.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.result_kind),
	.out_byte  (result.value_byte)
);

FILE: tb/tb_json_key_string_value_extractor_top.sv
// Testbench of the JSON key string value extractor: random JSON documents against a predictor.
`timescale 1ns / 1ps

module tb_json_key_string_value_extractor_top;
	import jkse_pkg::*;

	// Index 3 of the register channel selects no register; the block must ignore it.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	// Generous bound: roughly 550 bytes, each held up by gaps, stalls and two results,
	// plus one long hold-off of the receiver, then multiplied several times over.
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	// The scoreboard keeps its own copy of the key registers and of the parser state,
	// and a queue of the results that the document bytes seen so far must cause.
	class value_ledger;
		typedef struct packed {
			logic [1:0] kind;
			logic [7:0] vbyte;
		} outcome_t;

		outcome_t awaited[$];
		logic [CFG_DATA_W-1:0] key_lo;
		logic [CFG_DATA_W-1:0] key_hi;
		logic [KEY_LEN_W-1:0] key_len;
		phase_t ph;
		logic [KEY_POS_W-1:0] kpos;
		logic esc;
		int mismatches;

		function new();
			key_lo = '0;
			key_hi = '0;
			key_len = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			ph = PH_START;
			kpos = '0;
			esc = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_KEY_FIRST: key_lo = d;
				CFG_KEY_SECOND: key_hi = d;
				CFG_KEY_LENGTH: key_len = d[KEY_LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] key_char(int p);
			logic [CFG_DATA_W-1:0] w;
			w = (p < 8) ? key_lo : key_hi;
			return w[(p % 8) * 8 +: 8];
		endfunction

		// Lengths above the register capacity are clamped.
		function int eff_len();
			return (key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len);
		endfunction

		function bit blank(logic [7:0] b);
			return b == CH_SPACE || b == CH_NEWLINE || b == CH_TAB;
		endfunction

		function void add_outcome(kind_t k, logic [7:0] v);
			outcome_t o;
			o.kind = k;
			o.vbyte = v;
			awaited.push_back(o);
		endfunction

		function void after_miss(logic [7:0] b);
			if (b == CH_CLOSE) begin
				add_outcome(KIND_NONE, 8'h00);
				ph = PH_DONE;
			end else if (b == CH_COMMA) begin
				ph = PH_KEY_WS;
			end else begin
				ph = PH_SCAN;
			end
		endfunction

		// Works out the results of one accepted document byte.
		function void note_byte(logic [7:0] b, logic last);
			int len;
			len = eff_len();
			case (ph)
				PH_START: ph = PH_KEY_WS;
				PH_KEY_WS: begin
					if (!blank(b)) begin
						if (b == CH_CLOSE) begin
							add_outcome(KIND_NONE, 8'h00);
							ph = PH_DONE;
						end else begin
							kpos = '0;
							ph = PH_KEY_CMP;
						end
					end
				end
				PH_KEY_CMP: begin
					if (kpos < len && b != CH_QUOTE && b == key_char(kpos)) begin
						kpos = kpos + 1'b1;
					end else if (kpos >= len && b == CH_QUOTE) begin
						ph = PH_COLON;
					end else begin
						after_miss(b);
					end
				end
				PH_SCAN: after_miss(b);
				PH_COLON: begin
					if (!blank(b))
						ph = PH_VAL_WS;
				end
				PH_VAL_WS: begin
					if (!blank(b)) begin
						if (b == CH_QUOTE) begin
							ph = PH_VALUE;
							esc = 1'b0;
						end else begin
							add_outcome(KIND_BAD, 8'h00);
							ph = PH_DONE;
						end
					end
				end
				PH_VALUE: begin
					if (esc) begin
						add_outcome(KIND_BYTE, b);
						esc = 1'b0;
					end else if (b == CH_BACKSLASH) begin
						add_outcome(KIND_BYTE, b);
						esc = 1'b1;
					end else if (b == CH_QUOTE) begin
						add_outcome(KIND_END, 8'h00);
						ph = PH_DONE;
					end else begin
						add_outcome(KIND_BYTE, b);
					end
				end
				default: ph = PH_DONE;
			endcase
			if (last) begin
				if (ph == PH_START || ph == PH_KEY_WS || ph == PH_KEY_CMP || ph == PH_SCAN)
					add_outcome(KIND_NONE, 8'h00);
				else if (ph == PH_COLON || ph == PH_VAL_WS || ph == PH_VALUE)
					add_outcome(KIND_BAD, 8'h00);
				restart();
			end
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] v);
			outcome_t o;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d byte %02h", k, v);
			end else begin
				o = awaited.pop_front();
				if (o.kind != k || o.vbyte != v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
							o.kind, o.vbyte, k, v);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jkse_doc_if doc_ch ();
	jkse_cfg_if cfg_ch ();
	jkse_result_if res_ch ();

	json_key_string_value_extractor_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.doc(doc_ch),
		.cfg(cfg_ch),
		.result(res_ch)
	);

	always #2 clk = ~clk;

	value_ledger ledger;
	logic [7:0] doc_q[$];
	int sent_bytes = 0;
	int cycle_count = 0;
	// gaps_on belongs to the sender process alone; stalls_on and hold_asks are written by the
	// sender with nonblocking assignments and only read by the receiver.
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int hold_asks = 0;

	// Watchdog: a hung handshake ends the run here rather than never.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("json_key_string_value_extractor_top verification failed");
			$finish;
		end
	end

	// Result receiver. Each accepted transaction is checked against the oldest expectation.
	// Stalls come in short random bursts while stalls_on is set; when the sender asks for a
	// long hold-off, ready stays low until a countdown from LONG_HOLD runs out, so that the
	// internal queue fills and the block has to push back on its document input.
	initial begin
		int stall_left;
		int holds_seen;
		stall_left = 0;
		holds_seen = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				ledger.check_result(res_ch.result_kind, res_ch.value_byte);
			if (holds_seen != hold_asks) begin
				holds_seen = hold_asks;
				stall_left = LONG_HOLD;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			res_ch.ready <= (stall_left == 0);
		end
	end

	// One document byte transaction. A gap, when taken, lowers valid for a burst of cycles
	// first; valid is never lowered and raised again within the same edge.
	task automatic push_byte(logic [7:0] b, logic last);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			doc_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		doc_ch.valid <= 1'b1;
		doc_ch.doc_byte <= b;
		doc_ch.doc_last <= last;
		do @(posedge clk); while (!doc_ch.ready);
		ledger.note_byte(b, last);
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc_q.size(); i++)
			push_byte(doc_q[i], i == doc_q.size() - 1);
		sent_bytes += doc_q.size();
	endtask

	// Register write transaction. valid is left high so that writes can follow back to back;
	// the caller lowers it after the last one.
	task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		ledger.write_reg(idx, d);
	endtask

	// Registers may only change while the block is idle. A byte that causes no result can
	// still be in flight when the last expected result arrives, hence the extra cycles.
	task automatic wait_idle();
		doc_ch.valid <= 1'b0;
		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] letter();
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] letter_word();
		logic [CFG_DATA_W-1:0] w;
		for (int i = 0; i < 8; i++)
			w[i * 8 +: 8] = letter();
		return w;
	endfunction

	// Key settings of the random phases: empty key, full-width random key, all-ones key with an
	// over-long length, then short, over-long and random-length lowercase keys. The length
	// register gets random upper bits, which it ignores.
	task automatic configure(int setting);
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		lo = letter_word();
		hi = letter_word();
		case (setting)
			0: begin
				lo = '0;
				hi = '0;
				len_word[KEY_LEN_W-1:0] = 5'd0;
			end
			1: begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				len_word[KEY_LEN_W-1:0] = 5'd16;
			end
			2: begin
				lo = '1;
				hi = '1;
				len_word[KEY_LEN_W-1:0] = 5'd31;
			end
			3: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(1, 6));
			4: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(17, 30));
			default: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(1, 16));
		endcase
		put_reg(CFG_KEY_FIRST, lo);
		put_reg(CFG_KEY_SECOND, hi);
		put_reg(CFG_KEY_LENGTH, len_word);
		if (setting == 0)
			put_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic void load_text(string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endfunction

	function automatic void put_blanks();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: doc_q.push_back(CH_SPACE);
				1: doc_q.push_back(CH_NEWLINE);
				default: doc_q.push_back(CH_TAB);
			endcase
		end
	endfunction

	// style 0 writes the configured key, 1 a near miss (one bit flipped or one character too
	// many), anything else a short unrelated word.
	function automatic void put_key(int style);
		int len;
		int at;
		len = ledger.eff_len();
		doc_q.push_back(CH_QUOTE);
		case (style)
			0: for (int p = 0; p < len; p++) doc_q.push_back(ledger.key_char(p));
			1: begin
				at = $urandom_range(0, len);
				for (int p = 0; p < len; p++)
					doc_q.push_back(p == at ? ledger.key_char(p) ^ (8'd1 << $urandom_range(0, 7))
						: ledger.key_char(p));
				if (at == len)
					doc_q.push_back(letter());
			end
			default: repeat ($urandom_range(0, 5)) doc_q.push_back(letter());
		endcase
		doc_q.push_back(CH_QUOTE);
	endfunction

	// A quoted string with escapes and stray bytes except quote and backslash, or a bare number.
	function automatic void put_value(int n_chars, bit as_string);
		logic [7:0] c;
		if (!as_string) begin
			repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(8'h30, 8'h39)));
		end else begin
			doc_q.push_back(CH_QUOTE);
			repeat (n_chars) begin
				case ($urandom_range(0, 7))
					0: begin
						doc_q.push_back(CH_BACKSLASH);
						doc_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
					end
					1, 2: begin
						c = 8'($urandom_range(0, 255));
						doc_q.push_back((c == CH_QUOTE || c == CH_BACKSLASH) ? letter() : c);
					end
					default: doc_q.push_back(letter());
				endcase
			end
			doc_q.push_back(CH_QUOTE);
		end
	endfunction

	// Mostly well-formed objects with random members, some holding the configured key, plus a
	// share of pure noise, broken openings, wrong colons, trailing junk and early ends.
	function automatic void build_doc();
		int members;
		int target;
		int cut;
		doc_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) doc_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		doc_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h7B);
		members = $urandom_range(1, 4);
		target = ($urandom_range(0, 9) < 7) ? $urandom_range(0, members - 1) : members;
		for (int i = 0; i < members; i++) begin
			put_blanks();
			put_key(i == target ? 0 : $urandom_range(1, 2));
			put_blanks();
			doc_q.push_back(($urandom_range(0, 15) == 0) ? letter() : 8'h3A);
			put_blanks();
			put_value($urandom_range(0, 6), $urandom_range(0, 7) != 0);
			if (i < members - 1)
				doc_q.push_back(CH_COMMA);
		end
		put_blanks();
		doc_q.push_back(CH_CLOSE);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, doc_q.size() - 1);
			while (doc_q.size() > cut) doc_q.pop_back();
		end
	endfunction

	initial begin
		bit pressure_done;
		bit idle_now;
		int quota;
		ledger = new();
		pressure_done = 1'b0;
		doc_ch.valid <= 1'b0;
		doc_ch.doc_byte <= 8'h00;
		doc_ch.doc_last <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_KEY_FIRST;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the one-character key "a": a value with both byte extremes and an
		// escaped quote, an empty object with junk after the verdict, a bare number value, and
		// two documents that end early, one while matching the key and one inside the value.
		gaps_on = 1'b1;
		stalls_on <= 1'b1;
		put_reg(CFG_KEY_FIRST, 64'h61);
		put_reg(CFG_KEY_SECOND, '0);
		put_reg(CFG_KEY_LENGTH, 64'd1);
		cfg_ch.valid <= 1'b0;
		doc_q.delete();
		load_text("{\"a\":\"");
		doc_q.push_back(8'hFF);
		doc_q.push_back(CH_BACKSLASH);
		doc_q.push_back(CH_QUOTE);
		doc_q.push_back(8'h00);
		load_text("\"}");
		send_doc();
		doc_q.delete();
		load_text("{}x");
		send_doc();
		doc_q.delete();
		load_text("{\"a\":7}");
		send_doc();
		doc_q.delete();
		load_text("{\"a");
		send_doc();
		doc_q.delete();
		load_text("{\"a\":\"");
		send_doc();

		// Random part: six key settings of about seventy bytes each. The last setting runs
		// without any idling on either side.
		for (int setting = 0; setting < 6; setting++) begin
			wait_idle();
			configure(setting);
			quota = sent_bytes + 70;
			while (sent_bytes < quota) begin
				idle_now = (setting != 5) && ($urandom_range(0, 3) != 0);
				gaps_on = idle_now;
				stalls_on <= idle_now;
				if (setting == 3 && !pressure_done) begin
					// A long matching value sent flat out while the receiver holds off.
					pressure_done = 1'b1;
					gaps_on = 1'b0;
					hold_asks <= hold_asks + 1;
					doc_q.delete();
					doc_q.push_back(8'h7B);
					put_key(0);
					doc_q.push_back(8'h3A);
					put_value(40, 1'b1);
					doc_q.push_back(CH_CLOSE);
				end else begin
					build_doc();
				end
				send_doc();
			end
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (ledger.awaited.size() != 0)
			$display("%0d expected results never arrived", ledger.awaited.size());
		if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
			$display("json_key_string_value_extractor_top verification clean");
		end else begin
			$display("json_key_string_value_extractor_top verification failed");
		end
		$finish;
	end

endmodule

FILE: json_key_string_value_extractor_top.f
rtl/jkse_pkg.sv
rtl/jkse_ifs.sv
rtl/jkse_front.sv
rtl/jkse_queue.sv
rtl/jkse_back.sv
rtl/json_key_string_value_extractor_top.sv
rtl/jkse_checker.sv
tb/tb_json_key_string_value_extractor_top.sv
